[rtl/core/crs_pkg.sv]
// crs_pkg: shared types and constants of the catmull-rom segment tessellator
// used by crs_ctrl, crs_dpath and catmull_rom_segment_tessellator
// no dependencies
package crs_pkg;

  // coordinate format, signed q1.14
  localparam int COORD_W = 16;

  // parameter t, unsigned q1.16 held up to and including 1.0
  localparam int T_FRAC   = 16;
  localparam int T_W      = T_FRAC + 1;
  localparam int T_ONE    = 1 << T_FRAC;
  localparam int RND_HALF = 1 << (T_FRAC - 1);
  localparam int TSTEP_W  = 16;

  // step count register
  localparam int STEPS_W   = 7;
  localparam int MIN_STEPS = 3;
  localparam int MAX_STEPS_DEF = 64;

  // register reset values
  localparam logic [STEPS_W-1:0] STEPS_RST = STEPS_W'(50);
  localparam logic [TSTEP_W-1:0] TSTEP_RST = TSTEP_W'(1311);

  // register map, index taken from paddr[2]
  localparam int REG_IDX_W = 1;
  localparam int PADDR_W   = 3;
  localparam logic [REG_IDX_W-1:0] REG_SEGMENT_STEPS = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_T_STEP        = 1'b1;

  // control point transfer
  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      curve_start;
  } crs_in_t;

  // interpolated sample transfer
  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic                      run_last;
  } crs_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // point accepted, shift window and latch coefficients
    logic issue;  // start one sample in the pipeline
    logic last;   // the issued sample ends the segment
  } crs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic win_full;   // three points held
    logic pipe_busy;  // samples still in the multiply stages
    logic stall;      // output register held by the receiver
  } crs_sts_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } crs_state_t;

endpackage

[rtl/core/crs_ctrl.sv]
// crs_ctrl: sequencer of the tessellator, accepts points and issues samples
// depends on crs_pkg
module crs_ctrl import crs_pkg::*; #(
  parameter int MAX_STEPS = MAX_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               point_valid,
  output logic               point_ready,
  input  logic               curve_start,
  input  logic [STEPS_W-1:0] segment_steps,
  input  crs_sts_t           sts,
  output crs_cmd_t           cmd
);

  localparam int SW = $clog2(MAX_STEPS + 1);

  crs_state_t    state;
  crs_state_t    state_next;
  logic [SW-1:0] step_cnt;
  logic [SW-1:0] eff_steps;

  // clamp the step count to the supported range
  always_comb begin
    if (segment_steps < STEPS_W'(MIN_STEPS)) begin
      eff_steps = SW'(MIN_STEPS);
    end else if (segment_steps > STEPS_W'(MAX_STEPS)) begin
      eff_steps = SW'(MAX_STEPS);
    end else begin
      eff_steps = SW'(segment_steps);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.load && sts.win_full && !curve_start) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cmd.issue && cmd.last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    point_ready = 1'b0;
    cmd.load    = 1'b0;
    cmd.issue   = 1'b0;
    cmd.last    = (step_cnt == eff_steps - SW'(1));
    case (state)
      ST_IDLE: begin
        point_ready = 1'b1;
        cmd.load    = point_valid;
      end
      ST_RUN: begin
        cmd.issue = !sts.stall;
      end
      ST_DRAIN: begin
        cmd.issue = 1'b0;
      end
      default: begin
        point_ready = 1'b0;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sample counter within the segment
  always_ff @(posedge clk) begin
    if (rst) begin
      step_cnt <= '0;
    end else if (cmd.load) begin
      step_cnt <= '0;
    end else if (cmd.issue) begin
      step_cnt <= step_cnt + SW'(1);
    end
  end

`ifndef ASSERT_OFF
  a_no_issue_in_stall: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> !sts.stall) else $error("sample issued while output stalled");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (step_cnt < eff_steps)) else $error("step count overrun");

  a_full_window_runs: assert property (@(posedge clk) disable iff (rst)
    (cmd.load && sts.win_full && !curve_start) |=> (state == ST_RUN))
    else $error("full window did not start a segment");
`endif

endmodule

[rtl/core/crs_dpath.sv]
// crs_dpath: point window, coefficients and horner evaluation pipeline
// depends on crs_pkg
module crs_dpath import crs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  crs_cmd_t           cmd,
  output crs_sts_t           sts,
  input  crs_in_t            point,
  input  logic [TSTEP_W-1:0] t_step,
  output logic               sample_valid,
  input  logic               sample_ready,
  output crs_out_t           sample
);

  localparam int CF_W = COORD_W + 4;
  localparam int H_W  = COORD_W + 5;
  localparam int P_W  = H_W + T_W + 1;
  localparam logic signed [H_W-1:0] SAT_HI = H_W'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
  localparam logic signed [H_W-1:0] SAT_LO = -SAT_HI - H_W'(1);

  // round to nearest after dropping the t fraction
  function automatic logic signed [H_W-1:0] rnd_t(input logic signed [P_W-1:0] v);
    logic signed [P_W-1:0] s;
    s = v + P_W'(RND_HALF);
    return H_W'(s >>> T_FRAC);
  endfunction

  function automatic logic signed [CF_W-1:0] coef3(input logic signed [COORD_W-1:0] p0,
      input logic signed [COORD_W-1:0] p1, input logic signed [COORD_W-1:0] p2,
      input logic signed [COORD_W-1:0] p3);
    logic signed [CF_W-1:0] e0, e1, e2, e3;
    e0 = CF_W'(p0);
    e1 = CF_W'(p1);
    e2 = CF_W'(p2);
    e3 = CF_W'(p3);
    return e3 - e0 + e1 + (e1 <<< 1) - e2 - (e2 <<< 1);
  endfunction

  function automatic logic signed [CF_W-1:0] coef2(input logic signed [COORD_W-1:0] p0,
      input logic signed [COORD_W-1:0] p1, input logic signed [COORD_W-1:0] p2,
      input logic signed [COORD_W-1:0] p3);
    logic signed [CF_W-1:0] e0, e1, e2, e3;
    e0 = CF_W'(p0);
    e1 = CF_W'(p1);
    e2 = CF_W'(p2);
    e3 = CF_W'(p3);
    return (e0 <<< 1) - e1 - (e1 <<< 2) + (e2 <<< 2) - e3;
  endfunction

  logic signed [COORD_W-1:0] win [2][3];
  logic signed [COORD_W-1:0] pin [2];
  logic [1:0]                held;
  logic signed [CF_W-1:0]    c3 [2];
  logic signed [CF_W-1:0]    c2 [2];
  logic signed [CF_W-1:0]    c1 [2];
  logic signed [COORD_W-1:0] p1r [2];
  logic [T_W-1:0]            t_acc;
  logic [T_W:0]              t_sum;

  logic                      adv;
  logic                      v1, v2, v3;
  logic                      last1, last2, last3;
  logic [T_W-1:0]            t1, t2;
  logic signed [T_W:0]       st0, st1, st2;
  logic signed [P_W-1:0]     prod1 [2];
  logic signed [P_W-1:0]     prod2 [2];
  logic signed [P_W-1:0]     prod3 [2];
  logic signed [P_W-1:0]     m1 [2];
  logic signed [P_W-1:0]     m2 [2];
  logic signed [P_W-1:0]     m3 [2];
  logic signed [H_W-1:0]     h1 [2];
  logic signed [H_W-1:0]     h2 [2];
  logic signed [H_W-1:0]     h3 [2];
  logic signed [H_W-1:0]     hr [2];
  logic signed [H_W-1:0]     sat [2];

  assign pin[0] = point.point_x;
  assign pin[1] = point.point_y;

  // pipeline moves whenever the output register can take a new sample
  assign adv           = !sample_valid || sample_ready;
  assign sts.stall     = !adv;
  assign sts.pipe_busy = v1 || v2 || v3;
  assign sts.win_full  = (held == 2'd3);

  // saturating parameter accumulator, t = k * t_step clamped to one
  assign t_sum = {1'b0, t_acc} + (T_W + 1)'(t_step);

  assign st0 = {1'b0, t_acc};
  assign st1 = {1'b0, t1};
  assign st2 = {1'b0, t2};

  // horner steps, one multiply per stage
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      m1[l]  = P_W'(c3[l]) * P_W'(st0);
      h1[l]  = rnd_t(prod1[l]) + H_W'(c2[l]);
      m2[l]  = P_W'(h1[l]) * P_W'(st1);
      h2[l]  = rnd_t(prod2[l]) + H_W'(c1[l]);
      m3[l]  = P_W'(h2[l]) * P_W'(st2);
      h3[l]  = rnd_t(prod3[l]) + (H_W'(p1r[l]) <<< 1);
      hr[l]  = (h3[l] + H_W'(1)) >>> 1;
      if (hr[l] > SAT_HI) begin
        sat[l] = SAT_HI;
      end else if (hr[l] < SAT_LO) begin
        sat[l] = SAT_LO;
      end else begin
        sat[l] = hr[l];
      end
    end
  end

  // window shift and coefficient latch on each accepted point
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < 2; l++) begin
        for (int i = 0; i < 3; i++) begin
          win[l][i] <= '0;
        end
      end
    end else if (cmd.load) begin
      for (int l = 0; l < 2; l++) begin
        c3[l]     <= coef3(win[l][0], win[l][1], win[l][2], pin[l]);
        c2[l]     <= coef2(win[l][0], win[l][1], win[l][2], pin[l]);
        c1[l]     <= CF_W'(win[l][2]) - CF_W'(win[l][0]);
        p1r[l]    <= win[l][1];
        win[l][0] <= win[l][1];
        win[l][1] <= win[l][2];
        win[l][2] <= pin[l];
      end
    end
  end

  // fill level of the window
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 2'd0;
    end else if (cmd.load) begin
      if (point.curve_start) begin
        held <= 2'd1;
      end else if (held != 2'd3) begin
        held <= held + 2'd1;
      end
    end
  end

  // parameter accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      t_acc <= '0;
    end else if (cmd.load) begin
      t_acc <= '0;
    end else if (cmd.issue) begin
      if (t_sum >= (T_W + 1)'(T_ONE)) begin
        t_acc <= T_W'(T_ONE);
      end else begin
        t_acc <= T_W'(t_sum);
      end
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      sample_valid <= 1'b0;
    end else if (adv) begin
      v1           <= cmd.issue;
      v2           <= v1;
      v3           <= v2;
      sample_valid <= v3;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (adv) begin
      t1    <= t_acc;
      t2    <= t1;
      last1 <= cmd.last;
      last2 <= last1;
      last3 <= last2;
      for (int l = 0; l < 2; l++) begin
        prod1[l] <= m1[l];
        prod2[l] <= m2[l];
        prod3[l] <= m3[l];
      end
      if (v3) begin
        sample.out_x    <= COORD_W'(sat[0]);
        sample.out_y    <= COORD_W'(sat[1]);
        sample.run_last <= last3;
      end
    end
  end

`ifndef ASSERT_OFF
  a_load_when_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !(v1 || v2 || v3)) else $error("coefficients replaced under live samples");

  a_t_bounded: assert property (@(posedge clk) disable iff (rst)
    t_acc <= T_W'(T_ONE)) else $error("parameter accumulator beyond one");

  a_stage_reaches_out: assert property (@(posedge clk) disable iff (rst)
    (adv && v3) |=> sample_valid) else $error("sample lost at output stage");
`endif

endmodule

[rtl/core/catmull_rom_segment_tessellator.sv]
// Uniform catmull-rom segment tessellator.
// Channel point (point_valid/point_ready/point): control points, signed q1.14,
// with curve_start to begin a new curve. Channel sample (sample_valid/
// sample_ready/sample): interpolated points, run_last on the final one of each
// segment. APB port: register 0 segment_steps at 0x0, register 1 t_step at 0x4.
// From the fourth point of a curve on, each point yields segment_steps samples
// (clamped to 3..MAX_STEPS) of the segment between the middle window points.
// A point that yields samples holds point_ready low while its samples are
// issued, one sample per cycle while the output does not stall, into a
// three-stage multiply pipeline and then while the pipeline drains. Each
// sample passes the three multiply stages and then the output register.
// A point that yields nothing only enters the window; point_ready stays high.
// A held sample in the output register does not block the next point transfer.
// When the receiver stalls, the whole sample pipeline holds in place.
// Reset clears the window and the valids and sets the registers (50 steps, t_step 1311).
// Depends on crs_pkg, crs_ctrl and crs_dpath.
module catmull_rom_segment_tessellator import crs_pkg::*; #(
  parameter int MAX_STEPS = MAX_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               point_valid,
  output logic               point_ready,
  input  crs_in_t            point,
  output logic               sample_valid,
  input  logic               sample_ready,
  output crs_out_t           sample,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [STEPS_W-1:0]   segment_steps;
  logic [TSTEP_W-1:0]   t_step;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 reg_wr;
  crs_cmd_t             cmd;
  crs_sts_t             sts;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign reg_wr  = psel && penable && pwrite;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      segment_steps <= STEPS_RST;
      t_step        <= TSTEP_RST;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_SEGMENT_STEPS: segment_steps <= pwdata[STEPS_W-1:0];
        REG_T_STEP:        t_step        <= pwdata[TSTEP_W-1:0];
        default:           t_step        <= t_step;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      REG_SEGMENT_STEPS: prdata = 32'(segment_steps);
      REG_T_STEP:        prdata = 32'(t_step);
      default:           prdata = '0;
    endcase
  end

  crs_ctrl #(
    .MAX_STEPS(MAX_STEPS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .point_valid  (point_valid),
    .point_ready  (point_ready),
    .curve_start  (point.curve_start),
    .segment_steps(segment_steps),
    .sts          (sts),
    .cmd          (cmd)
  );

  crs_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .point       (point),
    .t_step      (t_step),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .sample      (sample)
  );

endmodule
